### design/irts_pkg.sv
// Package: command, action, status and phase codes for the I2C register sequencer.
`default_nettype none

package irts_pkg;

    typedef logic [1:0] action_t;
    typedef logic [2:0] command_t;
    typedef logic [2:0] phase_t;
    typedef logic [7:0] byte_t;
    typedef logic [6:0] dev_addr_t;

    localparam action_t ACT_WRITE = 2'd0;
    localparam action_t ACT_READ  = 2'd1;
    localparam action_t ACT_EVENT = 2'd2;

    localparam command_t CMD_NONE  = 3'd0;
    localparam command_t CMD_START = 3'd1;
    localparam command_t CMD_TX    = 3'd2;
    localparam command_t CMD_RACK  = 3'd3;
    localparam command_t CMD_RNACK = 3'd4;
    localparam command_t CMD_STOP  = 3'd5;

    localparam byte_t ST_START     = 8'h08;
    localparam byte_t ST_RSTART    = 8'h10;
    localparam byte_t ST_SLAW_ACK  = 8'h18;
    localparam byte_t ST_DATAW_ACK = 8'h28;
    localparam byte_t ST_SLAR_ACK  = 8'h40;

    localparam dev_addr_t DEV_ADDR_RESET = 7'h76;

    localparam phase_t PH_IDLE   = 3'd0;
    localparam phase_t PH_START  = 3'd1;
    localparam phase_t PH_SLAW   = 3'd2;
    localparam phase_t PH_REG    = 3'd3;
    localparam phase_t PH_DATA   = 3'd4;
    localparam phase_t PH_RSTART = 3'd5;
    localparam phase_t PH_SLAR   = 3'd6;
    localparam phase_t PH_RX     = 3'd7;

endpackage

`default_nettype wire

### design/i2c_register_transaction_sequencer.sv
// Top level: I2C master register read/write transaction sequencer.
//
// Input channel (s_*): one request per item, either a begin-write, a begin-read
// or a bus status event reported by the byte-level bus controller. Every
// accepted request produces exactly one result on the m_* channel: the next
// controller command, an optional received byte, and transaction completion.
// Configuration channel (cfg_*): sets the 7-bit device address; always ready.
//
// The result is valid in the cycle after request acceptance. Throughput is
// one request per cycle while the receiver does not stall: the transaction state
// and the result register are updated in the same cycle by a single pass through the phase decode.
// When the receiver stalls, the result stays held in the output register and
// s_ready drops until it is taken; s_ready is high whenever the output register
// is empty or is being emptied in that cycle.
//
// Reset (aresetn low, synchronous) returns the sequencer to idle, clears the
// output valid flag and restores the device address to 0x76.
`default_nettype none

module i2c_register_transaction_sequencer (
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire irts_pkg::dev_addr_t cfg_wdata,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire irts_pkg::action_t s_action,
    input  wire irts_pkg::byte_t   s_register_address,
    input  wire irts_pkg::byte_t   s_write_data,
    input  wire irts_pkg::byte_t   s_read_length,
    input  wire irts_pkg::byte_t   s_bus_status,
    input  wire irts_pkg::byte_t   s_bus_data,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output irts_pkg::command_t     m_command,
    output irts_pkg::byte_t        m_tx_byte,
    output logic                   m_rx_valid,
    output irts_pkg::byte_t        m_rx_byte,
    output irts_pkg::byte_t        m_rx_index,
    output logic                   m_done_res,
    output logic                   m_success
);
    import irts_pkg::*;

    dev_addr_t dev_addr_reg;
    phase_t    phase_reg, phase_next;
    logic      is_read_reg, is_read_next;
    byte_t     saved_reg_reg, saved_reg_next;
    byte_t     saved_data_reg, saved_data_next;
    byte_t     bytes_left_reg, bytes_left_next;
    byte_t     byte_count_reg, byte_count_next;

    logic      m_valid_reg;
    command_t  cmd_reg, cmd_next;
    byte_t     tx_reg, tx_next;
    logic      rxv_reg, rxv_next;
    byte_t     rxb_reg, rxb_next;
    byte_t     rxi_reg, rxi_next;
    logic      done_reg, done_next;
    logic      ok_reg, ok_next;

    logic      fail;
    logic      accept;
    byte_t     addr_w;
    byte_t     addr_r;
    byte_t     left_dec;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign addr_w    = {dev_addr_reg, 1'b0};
    assign addr_r    = {dev_addr_reg, 1'b1};
    assign left_dec  = bytes_left_reg - 8'd1;

    always_comb begin
        phase_next      = phase_reg;
        is_read_next    = is_read_reg;
        saved_reg_next  = saved_reg_reg;
        saved_data_next = saved_data_reg;
        bytes_left_next = bytes_left_reg;
        byte_count_next = byte_count_reg;
        cmd_next        = CMD_NONE;
        tx_next         = 8'd0;
        rxv_next        = 1'b0;
        rxb_next        = 8'd0;
        rxi_next        = 8'd0;
        done_next       = 1'b0;
        ok_next         = 1'b0;
        fail            = 1'b0;

        unique case (s_action) inside
            ACT_WRITE, ACT_READ: begin
                if (phase_reg == PH_IDLE) begin
                    is_read_next    = (s_action == ACT_READ);
                    saved_reg_next  = s_register_address;
                    saved_data_next = s_write_data;
                    bytes_left_next = s_read_length;
                    byte_count_next = 8'd0;
                    phase_next      = PH_START;
                    cmd_next        = CMD_START;
                end
            end
            ACT_EVENT: begin
                unique case (phase_reg)
                    PH_IDLE: begin
                    end
                    PH_START: begin
                        if (s_bus_status == ST_START || s_bus_status == ST_RSTART) begin
                            cmd_next   = CMD_TX;
                            tx_next    = addr_w;
                            phase_next = PH_SLAW;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    PH_SLAW: begin
                        if (s_bus_status == ST_SLAW_ACK) begin
                            cmd_next   = CMD_TX;
                            tx_next    = saved_reg_reg;
                            phase_next = PH_REG;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    PH_REG: begin
                        if (s_bus_status == ST_DATAW_ACK) begin
                            if (is_read_reg) begin
                                cmd_next   = CMD_START;
                                phase_next = PH_RSTART;
                            end else begin
                                cmd_next   = CMD_TX;
                                tx_next    = saved_data_reg;
                                phase_next = PH_DATA;
                            end
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    PH_DATA: begin
                        if (s_bus_status == ST_DATAW_ACK) begin
                            cmd_next   = CMD_STOP;
                            done_next  = 1'b1;
                            ok_next    = 1'b1;
                            phase_next = PH_IDLE;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    PH_RSTART: begin
                        if (s_bus_status == ST_RSTART) begin
                            cmd_next   = CMD_TX;
                            tx_next    = addr_r;
                            phase_next = PH_SLAR;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    PH_SLAR: begin
                        if (s_bus_status == ST_SLAR_ACK) begin
                            byte_count_next = 8'd0;
                            if (bytes_left_reg == 8'd0) begin
                                cmd_next   = CMD_STOP;
                                done_next  = 1'b1;
                                ok_next    = 1'b1;
                                phase_next = PH_IDLE;
                            end else begin
                                cmd_next   = (bytes_left_reg > 8'd1) ? CMD_RACK : CMD_RNACK;
                                phase_next = PH_RX;
                            end
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    PH_RX: begin
                        // data-phase status is not checked
                        rxv_next        = 1'b1;
                        rxb_next        = s_bus_data;
                        rxi_next        = byte_count_reg;
                        byte_count_next = byte_count_reg + 8'd1;
                        bytes_left_next = left_dec;
                        if (left_dec == 8'd0) begin
                            cmd_next   = CMD_STOP;
                            done_next  = 1'b1;
                            ok_next    = 1'b1;
                            phase_next = PH_IDLE;
                        end else begin
                            cmd_next = (left_dec > 8'd1) ? CMD_RACK : CMD_RNACK;
                        end
                    end
                    default: begin
                    end
                endcase
                if (fail) begin
                    cmd_next   = CMD_STOP;
                    tx_next    = 8'd0;
                    done_next  = 1'b1;
                    ok_next    = 1'b0;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg   <= DEV_ADDR_RESET;
            phase_reg      <= PH_IDLE;
            is_read_reg    <= 1'b0;
            saved_reg_reg  <= 8'd0;
            saved_data_reg <= 8'd0;
            bytes_left_reg <= 8'd0;
            byte_count_reg <= 8'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                dev_addr_reg <= cfg_wdata;
            end
            if (accept) begin
                phase_reg      <= phase_next;
                is_read_reg    <= is_read_next;
                saved_reg_reg  <= saved_reg_next;
                saved_data_reg <= saved_data_next;
                bytes_left_reg <= bytes_left_next;
                byte_count_reg <= byte_count_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= cmd_next;
            tx_reg   <= tx_next;
            rxv_reg  <= rxv_next;
            rxb_reg  <= rxb_next;
            rxi_reg  <= rxi_next;
            done_reg <= done_next;
            ok_reg   <= ok_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_command  = cmd_reg;
    assign m_tx_byte  = tx_reg;
    assign m_rx_valid = rxv_reg;
    assign m_rx_byte  = rxb_reg;
    assign m_rx_index = rxi_reg;
    assign m_done_res = done_reg;
    assign m_success  = ok_reg;

    a_done_is_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && done_reg) |-> (cmd_reg == CMD_STOP))
        else $error("transaction end without stop command");

    a_success_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && ok_reg) |-> done_reg)
        else $error("success flagged without transaction end");

    a_rx_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && rxv_reg) |->
            (cmd_reg == CMD_RACK || cmd_reg == CMD_RNACK || cmd_reg == CMD_STOP))
        else $error("received byte with non-receive command");

    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && done_next) |=> (phase_reg == PH_IDLE))
        else $error("sequencer not idle after transaction end");

    a_rx_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_RX) |-> (bytes_left_reg != 8'd0))
        else $error("receive phase with no bytes left");

endmodule

`default_nettype wire

### test/i2c_register_transaction_sequencer_tb.sv
// Testbench for the I2C register transaction sequencer: random and directed requests, scoreboard.
`timescale 1ns / 100ps

module i2c_register_transaction_sequencer_tb;
    import irts_pkg::*;

    localparam action_t ACT_UNUSED  = 2'd3;
    localparam int      ITEM_TARGET = 1250;
    localparam int      NUM_PHASES  = 6;
    localparam int      CYCLE_LIMIT = 400000;
    localparam int      LONG_HOLD   = 300;
    localparam byte_t   ST_BOGUS    = 8'h20;

    typedef struct packed {
        action_t action;
        byte_t   register_address;
        byte_t   write_data;
        byte_t   read_length;
        byte_t   bus_status;
        byte_t   bus_data;
    } request_t;

    typedef struct packed {
        command_t command;
        byte_t    tx_byte;
        logic     rx_valid;
        byte_t    rx_byte;
        byte_t    rx_index;
        logic     done_res;
        logic     success;
    } result_t;

    class command_scoreboard;
        dev_addr_t device_address = DEV_ADDR_RESET;
        phase_t    phase          = PH_IDLE;
        logic      is_read        = 1'b0;
        byte_t     saved_register = '0;
        byte_t     saved_data     = '0;
        byte_t     bytes_left     = '0;
        byte_t     byte_count     = '0;
        result_t   pending_commands[$];
        int        n_active       = 0;
        int        n_ignored      = 0;
        int        n_completed    = 0;
        int        n_aborted      = 0;
        int        n_rx_bytes     = 0;
        int        n_checked      = 0;
        int        n_errors       = 0;

        // Advance the sequencer state for one accepted request, queue its command.
        function void note_request(request_t r);
            result_t res;
            logic    bad;
            byte_t   addr_byte;
            res       = '0;
            bad       = 1'b0;
            addr_byte = {device_address, 1'b0};
            case (r.action)
                ACT_WRITE, ACT_READ: begin
                    if (phase == PH_IDLE) begin
                        is_read        = (r.action == ACT_READ);
                        saved_register = r.register_address;
                        saved_data     = r.write_data;
                        bytes_left     = r.read_length;
                        byte_count     = '0;
                        phase          = PH_START;
                        res.command    = CMD_START;
                    end
                end
                ACT_EVENT: begin
                    case (phase)
                        PH_START: begin
                            if (r.bus_status == ST_START || r.bus_status == ST_RSTART) begin
                                res.command = CMD_TX;
                                res.tx_byte = addr_byte;
                                phase       = PH_SLAW;
                            end else bad = 1'b1;
                        end
                        PH_SLAW: begin
                            if (r.bus_status == ST_SLAW_ACK) begin
                                res.command = CMD_TX;
                                res.tx_byte = saved_register;
                                phase       = PH_REG;
                            end else bad = 1'b1;
                        end
                        PH_REG: begin
                            if (r.bus_status != ST_DATAW_ACK) begin
                                bad = 1'b1;
                            end else if (is_read) begin
                                res.command = CMD_START;
                                phase       = PH_RSTART;
                            end else begin
                                res.command = CMD_TX;
                                res.tx_byte = saved_data;
                                phase       = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            if (r.bus_status == ST_DATAW_ACK) begin
                                res.command  = CMD_STOP;
                                res.done_res = 1'b1;
                                res.success  = 1'b1;
                                phase        = PH_IDLE;
                            end else bad = 1'b1;
                        end
                        PH_RSTART: begin
                            if (r.bus_status == ST_RSTART) begin
                                res.command = CMD_TX;
                                res.tx_byte = addr_byte | 8'h01;
                                phase       = PH_SLAR;
                            end else bad = 1'b1;
                        end
                        PH_SLAR: begin
                            if (r.bus_status != ST_SLAR_ACK) begin
                                bad = 1'b1;
                            end else begin
                                byte_count = '0;
                                if (bytes_left == 0) begin
                                    res.command  = CMD_STOP;
                                    res.done_res = 1'b1;
                                    res.success  = 1'b1;
                                    phase        = PH_IDLE;
                                end else begin
                                    res.command = (bytes_left > 1) ? CMD_RACK : CMD_RNACK;
                                    phase       = PH_RX;
                                end
                            end
                        end
                        PH_RX: begin
                            // status is not checked while receiving
                            res.rx_valid = 1'b1;
                            res.rx_byte  = r.bus_data;
                            res.rx_index = byte_count;
                            byte_count   = byte_count + 8'd1;
                            bytes_left   = bytes_left - 8'd1;
                            n_rx_bytes++;
                            if (bytes_left == 0) begin
                                res.command  = CMD_STOP;
                                res.done_res = 1'b1;
                                res.success  = 1'b1;
                                phase        = PH_IDLE;
                            end else begin
                                res.command = (bytes_left > 1) ? CMD_RACK : CMD_RNACK;
                            end
                        end
                        default: ;
                    endcase
                    if (bad) begin
                        res         = '0;
                        res.command = CMD_STOP;
                        res.done_res = 1'b1;
                        phase       = PH_IDLE;
                    end
                end
                default: ;
            endcase
            if (res.done_res) begin
                if (res.success) n_completed++;
                else n_aborted++;
            end
            if (res.command == CMD_NONE) n_ignored++;
            else n_active++;
            pending_commands.push_back(res);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_commands.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("%0t: unexpected result cmd %0d tx %02h", $realtime, got.command,
                             got.tx_byte);
                return;
            end
            want = pending_commands.pop_front();
            n_checked++;
            if (got !== want) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("%0t: mismatch on result %0d", $realtime, n_checked);
                    $display("  exp cmd %0d tx %02h rxv %b rxb %02h rxi %0d done %b ok %b",
                             want.command, want.tx_byte, want.rx_valid, want.rx_byte,
                             want.rx_index, want.done_res, want.success);
                    $display("  got cmd %0d tx %02h rxv %b rxb %02h rxi %0d done %b ok %b",
                             got.command, got.tx_byte, got.rx_valid, got.rx_byte,
                             got.rx_index, got.done_res, got.success);
                end
            end
        endfunction
    endclass

    logic      aclk               = 1'b0;
    logic      aresetn            = 1'b0;
    logic      cfg_valid          = 1'b0;
    logic      cfg_ready;
    dev_addr_t cfg_wdata          = '0;
    logic      s_valid            = 1'b0;
    logic      s_ready;
    action_t   s_action           = ACT_WRITE;
    byte_t     s_register_address = '0;
    byte_t     s_write_data       = '0;
    byte_t     s_read_length      = '0;
    byte_t     s_bus_status       = '0;
    byte_t     s_bus_data         = '0;
    logic      m_valid;
    logic      m_ready            = 1'b0;
    command_t  m_command;
    byte_t     m_tx_byte;
    logic      m_rx_valid;
    byte_t     m_rx_byte;
    byte_t     m_rx_index;
    logic      m_done_res;
    logic      m_success;

    command_scoreboard sb;
    logic src_quiet  = 1'b0;
    logic sink_quiet = 1'b0;
    int   sink_hold  = 0;
    int   cycle_count = 0;
    int   n_addresses = 0;

    i2c_register_transaction_sequencer u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_register_address (s_register_address),
        .s_write_data       (s_write_data),
        .s_read_length      (s_read_length),
        .s_bus_status       (s_bus_status),
        .s_bus_data         (s_bus_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_command          (m_command),
        .m_tx_byte          (m_tx_byte),
        .m_rx_valid         (m_rx_valid),
        .m_rx_byte          (m_rx_byte),
        .m_rx_index         (m_rx_index),
        .m_done_res         (m_done_res),
        .m_success          (m_success)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("i2c_register_transaction_sequencer_tb NOT OK");
        $finish;
    end

    function automatic request_t mk(action_t a, byte_t rg, byte_t wd, byte_t ln, byte_t st,
                                    byte_t bd);
        request_t r;
        r.action           = a;
        r.register_address = rg;
        r.write_data       = wd;
        r.read_length      = ln;
        r.bus_status       = st;
        r.bus_data         = bd;
        return r;
    endfunction

    function automatic request_t random_request(action_t a);
        return mk(a, byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
                  byte_t'($urandom), byte_t'($urandom));
    endfunction

    function automatic byte_t good_status(phase_t ph);
        case (ph)
            PH_START:       return $urandom_range(0, 1) ? ST_START : ST_RSTART;
            PH_SLAW:        return ST_SLAW_ACK;
            PH_REG, PH_DATA: return ST_DATAW_ACK;
            PH_RSTART:      return ST_RSTART;
            PH_SLAR:        return ST_SLAR_ACK;
            default:        return byte_t'($urandom);
        endcase
    endfunction

    // Valid stays high after acceptance; the next call or drain_results decides what follows.
    task automatic send_request(input request_t r);
        int gap;
        if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
        gap = src_quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_action           <= r.action;
        s_register_address <= r.register_address;
        s_write_data       <= r.write_data;
        s_read_length      <= r.read_length;
        s_bus_status       <= r.bus_status;
        s_bus_data         <= r.bus_data;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(r);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending_commands.size() != 0);
    endtask

    task automatic write_device_address(input dev_addr_t a);
        drain_results();
        repeat (2) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= a;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.device_address = a;
        n_addresses++;
    endtask

    // One begin request followed by status events until the sequencer is idle again.
    task automatic run_transaction(input int forced_len);
        request_t r;
        r = random_request($urandom_range(0, 1) ? ACT_READ : ACT_WRITE);
        if (forced_len >= 0) begin
            r.action      = ACT_READ;
            r.read_length = byte_t'(forced_len);
        end else begin
            case ($urandom_range(0, 19))
                0:       r.read_length = byte_t'($urandom);
                1:       r.read_length = 8'd0;
                default: r.read_length = byte_t'($urandom_range(1, 6));
            endcase
        end
        send_request(r);
        while (sb.phase != PH_IDLE) begin
            if ($urandom_range(0, 29) == 0)
                send_request(random_request(action_t'($urandom_range(0, 3))));
            r = random_request(ACT_EVENT);
            r.bus_status = good_status(sb.phase);
            if (sb.phase != PH_RX && $urandom_range(0, 39) == 0)
                r.bus_status = byte_t'($urandom);
            send_request(r);
        end
    endtask

    initial begin
        result_t got;
        do @(posedge aclk); while (!aresetn);
        forever begin
            int gap;
            if (sink_hold > 0) begin
                gap       = sink_hold;
                sink_hold = 0;
            end else begin
                if ($urandom_range(0, 49) == 0) sink_quiet = !sink_quiet;
                gap = sink_quiet ? 0 : $urandom_range(0, 10);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = '{command: m_command, tx_byte: m_tx_byte, rx_valid: m_rx_valid,
                    rx_byte: m_rx_byte, rx_index: m_rx_index, done_res: m_done_res,
                    success: m_success};
            sb.check_result(got);
        end
    end

    initial begin
        int phase_end;
        sb = new;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle noise, write, busy begin, zero-length read, two-byte read, abort
        send_request(mk(ACT_EVENT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_request(mk(ACT_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_request(mk(ACT_WRITE, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00));
        send_request(mk(ACT_EVENT, 8'h00, 8'h00, 8'h00, ST_RSTART, 8'h00));
        send_request(mk(ACT_READ, 8'h12, 8'h34, 8'h05, 8'h00, 8'h00));
        send_request(mk(ACT_EVENT, 8'h00, 8'h00, 8'h00, ST_SLAW_ACK, 8'h00));
        send_request(mk(ACT_EVENT, 8'h00, 8'h00, 8'h00, ST_DATAW_ACK, 8'h00));
        send_request(mk(ACT_EVENT, 8'h00, 8'h00, 8'h00, ST_DATAW_ACK, 8'h00));
        send_request(mk(ACT_READ, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF));
        send_request(mk(ACT_EVENT, 8'h00, 8'h00, 8'h00, ST_START, 8'h00));
        send_request(mk(ACT_EVENT, 8'h00, 8'h00, 8'h00, ST_SLAW_ACK, 8'h00));
        send_request(mk(ACT_EVENT, 8'h00, 8'h00, 8'h00, ST_DATAW_ACK, 8'h00));
        send_request(mk(ACT_EVENT, 8'h00, 8'h00, 8'h00, ST_RSTART, 8'h00));
        send_request(mk(ACT_EVENT, 8'h00, 8'h00, 8'h00, ST_SLAR_ACK, 8'h00));
        send_request(mk(ACT_READ, 8'hA5, 8'h00, 8'h02, 8'h00, 8'h00));
        send_request(mk(ACT_EVENT, 8'h00, 8'h00, 8'h00, ST_START, 8'h00));
        send_request(mk(ACT_EVENT, 8'h00, 8'h00, 8'h00, ST_SLAW_ACK, 8'h00));
        send_request(mk(ACT_EVENT, 8'h00, 8'h00, 8'h00, ST_DATAW_ACK, 8'h00));
        send_request(mk(ACT_EVENT, 8'h00, 8'h00, 8'h00, ST_RSTART, 8'h00));
        send_request(mk(ACT_EVENT, 8'h00, 8'h00, 8'h00, ST_SLAR_ACK, 8'h00));
        send_request(mk(ACT_EVENT, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF));
        send_request(mk(ACT_EVENT, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00));
        send_request(mk(ACT_WRITE, 8'h5A, 8'hC3, 8'h00, 8'h00, 8'h00));
        send_request(mk(ACT_EVENT, 8'h00, 8'h00, 8'h00, ST_START, 8'h00));
        send_request(mk(ACT_EVENT, 8'h00, 8'h00, 8'h00, ST_BOGUS, 8'h00));

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       write_device_address(7'h7F);
                1:       write_device_address(7'h00);
                default: write_device_address(dev_addr_t'($urandom));
            endcase
            if (p == 2) sink_hold = LONG_HOLD;
            if (p == 3) run_transaction(255);
            phase_end = (ITEM_TARGET * (p + 1)) / NUM_PHASES;
            while (sb.n_active < phase_end) begin
                if ($urandom_range(0, 9) == 0)
                    send_request(random_request($urandom_range(0, 1) ? ACT_EVENT : ACT_UNUSED));
                run_transaction(-1);
                if ($urandom_range(0, 39) == 0) drain_results();
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        $display("requests: %0d acted on, %0d ignored; %0d results checked over %0d addresses",
                 sb.n_active, sb.n_ignored, sb.n_checked, n_addresses);
        $display("transactions: %0d completed, %0d aborted; %0d bytes received",
                 sb.n_completed, sb.n_aborted, sb.n_rx_bytes);
        if (sb.n_errors == 0 && sb.pending_commands.size() == 0) begin
            $display("i2c_register_transaction_sequencer_tb OK");
        end else begin
            $display("%0d errors, %0d results missing", sb.n_errors,
                     sb.pending_commands.size());
            $display("i2c_register_transaction_sequencer_tb NOT OK");
        end
        $finish;
    end

endmodule
